/* hdl/rmsn_pkg.sv */
// ============================================================================
// rmsn_pkg: shared types and constants of the RMS normalizer
// Item classes, queue entry layout, multiplier handshake and the fixed
// constants of the inverse square root iteration.
// ============================================================================
package rmsn_pkg;

  localparam int unsigned MAX_LENGTH_DEF = 4096;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned ISQRT_STEPS    = 5;
  localparam int unsigned STEP_W         = 3;

  localparam logic [15:0] EPS_RESET  = 16'd17;
  localparam logic [31:0] Z_INIT_LO  = 32'd1805811301;
  localparam logic [31:0] Z_INIT_HI  = 32'd1276901417;
  localparam logic [63:0] THREE_Q62  = 64'hC000_0000_0000_0000;
  localparam logic [31:0] Z_CAP      = 32'h8000_0000;
  localparam logic [31:0] F_LOW      = 32'h4000_0000;

  typedef enum logic [1:0] {
    CLS_ACC,
    CLS_ACC_LAST,
    CLS_NORM
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [15:0] sample;
    logic [15:0] gain;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [32:0] a;
    logic [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

endpackage

/* hdl/rmsn_front.sv */
// ============================================================================
// rmsn_front: input acceptance, classification and item queue
// Classifies each accepted item and holds it in a short queue until the
// back end takes it.
// ============================================================================
module rmsn_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_kind,
  input  logic [15:0]      in_sample,
  input  logic [15:0]      in_gain,
  input  logic             in_end_of_pass,
  output logic             q_valid,
  output rmsn_pkg::item_t  q_head,
  input  logic             q_pop
);

  localparam int unsigned PTR_W = (rmsn_pkg::QDEPTH > 1) ? $clog2(rmsn_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(rmsn_pkg::QDEPTH + 1);

  rmsn_pkg::item_t q_r [rmsn_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  rmsn_pkg::item_t  item;

  assign busy    = (cnt_r == CNT_W'(rmsn_pkg::QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_r[rd_ptr_r];

  always_comb begin
    item.sample = in_sample;
    item.gain   = in_gain;
    if (in_kind) begin
      item.cls = rmsn_pkg::CLS_NORM;
    end else if (in_end_of_pass) begin
      item.cls = rmsn_pkg::CLS_ACC_LAST;
    end else begin
      item.cls = rmsn_pkg::CLS_ACC;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(rmsn_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(rmsn_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* hdl/rmsn_seqmul.sv */
// ============================================================================
// rmsn_seqmul: shift-and-add multiplier
// Multiplies two 33-bit unsigned operands one multiplier bit per cycle.
// ============================================================================
module rmsn_seqmul (
  input  logic               clk,
  input  logic               rst_n,
  input  rmsn_pkg::mul_req_t req,
  output rmsn_pkg::mul_rsp_t rsp
);

  logic        busy_r;
  logic [63:0] a_r;
  logic [32:0] b_r;
  logic [63:0] acc_r;

  assign rsp.done = busy_r && (b_r == '0);
  assign rsp.prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (rsp.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= {31'b0, req.a};
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[62:0], 1'b0};
      b_r <= {1'b0, b_r[32:1]};
    end
  end

endmodule

/* hdl/rmsn_back.sv */
// ============================================================================
// rmsn_back: execution sequencer
// Accumulates squares, divides for the mean square, runs the Newton
// inverse square root and scales normalize items.
// ============================================================================
module rmsn_back #(
  parameter int unsigned MAX_LENGTH = rmsn_pkg::MAX_LENGTH_DEF,
  parameter int unsigned CNT_W      = $clog2(MAX_LENGTH + 1),
  parameter int unsigned SUM_W      = 30 + CNT_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               q_valid,
  input  rmsn_pkg::item_t    q_head,
  output logic               q_pop,
  output rmsn_pkg::mul_req_t mreq,
  input  rmsn_pkg::mul_rsp_t mrsp,
  output logic               out_valid,
  output logic [15:0]        out_normalized,
  output logic               out_clipped
);

  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
  localparam int unsigned STEP_W_L = rmsn_pkg::STEP_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MSET, ST_NRM, ST_MZZ, ST_MPF, ST_MZT, ST_FIN, ST_NM2
  } state_t;

  state_t            state_r;
  logic [15:0]       eps_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  count_r;
  logic [31:0]       inv_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  den_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [31:0]       f_r;
  logic [3:0]        k_r;
  logic [31:0]       z_r;
  logic [32:0]       zz_r;
  logic [32:0]       ts_r;
  logic [STEP_W_L-1:0] step_r;
  logic              pend_r;
  logic signed [31:0] sg_r;
  logic              out_valid_r;
  logic [15:0]       out_norm_r;
  logic              out_clip_r;

  logic               take;
  logic [SUM_W-1:0]   sum_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic signed [31:0] sq;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_diff;
  logic [31:0]        m_val;
  logic [63:0]        t_val;
  logic [31:0]        zq;
  logic [46:0]        zk;
  logic [31:0]        mag;
  logic [62:0]        pr;
  logic [63:0]        rnd;
  logic [29:0]        r_val;

  assign q_pop          = (state_r == ST_IDLE) && q_valid;
  assign out_valid      = out_valid_r;
  assign out_normalized = out_norm_r;
  assign out_clipped    = out_clip_r;

  always_comb begin
    sq       = $signed(q_head.sample) * $signed(q_head.sample);
    take     = (count_r < CNT_W'(MAX_LENGTH));
    sum_nxt  = take ? sum_r + SUM_W'(sq[30:0]) : sum_r;
    cnt_nxt  = take ? count_r + 1'b1 : count_r;
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    m_val    = 32'(quo_r[30:0]) + 32'(eps_r);
    t_val    = (mrsp.prod > rmsn_pkg::THREE_Q62) ? 64'd0 : rmsn_pkg::THREE_Q62 - mrsp.prod;
    zq       = (mrsp.prod[63:32] > rmsn_pkg::Z_CAP) ? rmsn_pkg::Z_CAP : mrsp.prod[63:32];
    zk       = 47'(z_r) << k_r;
    mag      = sg_r[31] ? 32'(-sg_r) : 32'(sg_r);
    pr       = 63'(mag[30:0]) * 63'(inv_r);
    rnd      = 64'(pr) + 64'h2_0000_0000;
    r_val    = rnd[63:34];
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = {1'b0, z_r};
    mreq.b     = {1'b0, z_r};
    unique case (state_r)
      ST_MZZ: begin
        mreq.start = !pend_r;
      end
      ST_MPF: begin
        mreq.start = !pend_r;
        mreq.a     = zz_r;
        mreq.b     = {1'b0, f_r};
      end
      ST_MZT: begin
        mreq.start = !pend_r;
        mreq.b     = ts_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eps_r       <= rmsn_pkg::EPS_RESET;
      sum_r       <= '0;
      count_r     <= '0;
      inv_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_head.cls)
              rmsn_pkg::CLS_ACC: begin
                sum_r   <= sum_nxt;
                count_r <= cnt_nxt;
              end
              rmsn_pkg::CLS_ACC_LAST: begin
                sum_r   <= '0;
                count_r <= '0;
                quo_r   <= (cnt_nxt == '0) ? '0 : sum_nxt;
                rem_r   <= '0;
                den_r   <= cnt_nxt;
                dcnt_r  <= '0;
                state_r <= (cnt_nxt == '0) ? ST_MSET : ST_DIV;
              end
              rmsn_pkg::CLS_NORM: begin
                sg_r    <= $signed(q_head.sample) * $signed(q_head.gain);
                state_r <= ST_NM2;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (!rem_diff[CNT_W]) begin
            rem_r <= rem_diff[CNT_W-1:0];
            quo_r <= {quo_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[CNT_W-1:0];
            quo_r <= {quo_r[SUM_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
            state_r <= ST_MSET;
          end
        end
        ST_MSET: begin
          if (m_val == '0) begin
            inv_r   <= 32'hFFFF_FFFF;
            state_r <= ST_IDLE;
          end else begin
            f_r     <= m_val;
            k_r     <= '0;
            state_r <= ST_NRM;
          end
        end
        ST_NRM: begin
          if (f_r < rmsn_pkg::F_LOW) begin
            f_r <= {f_r[29:0], 2'b00};
            k_r <= k_r + 1'b1;
          end else begin
            z_r     <= f_r[31] ? rmsn_pkg::Z_INIT_HI : rmsn_pkg::Z_INIT_LO;
            step_r  <= '0;
            state_r <= ST_MZZ;
          end
        end
        ST_MZZ: begin
          if (mreq.start) begin
            pend_r <= 1'b1;
          end else if (mrsp.done) begin
            pend_r  <= 1'b0;
            zz_r    <= mrsp.prod[62:30];
            state_r <= ST_MPF;
          end
        end
        ST_MPF: begin
          if (mreq.start) begin
            pend_r <= 1'b1;
          end else if (mrsp.done) begin
            pend_r  <= 1'b0;
            ts_r    <= t_val[63:31];
            state_r <= ST_MZT;
          end
        end
        ST_MZT: begin
          if (mreq.start) begin
            pend_r <= 1'b1;
          end else if (mrsp.done) begin
            pend_r <= 1'b0;
            z_r    <= zq;
            step_r <= step_r + 1'b1;
            state_r <= (step_r == STEP_W_L'(rmsn_pkg::ISQRT_STEPS - 1)) ? ST_FIN : ST_MZZ;
          end
        end
        ST_FIN: begin
          inv_r   <= zk[46] ? 32'hFFFF_FFFF : zk[45:14];
          state_r <= ST_IDLE;
        end
        ST_NM2: begin
          out_valid_r <= 1'b1;
          if (sg_r[31]) begin
            if (r_val > 30'd32768) begin
              out_norm_r <= 16'h8000;
              out_clip_r <= 1'b1;
            end else begin
              out_norm_r <= 16'(30'd0 - r_val);
              out_clip_r <= 1'b0;
            end
          end else begin
            if (r_val > 30'd32767) begin
              out_norm_r <= 16'h7FFF;
              out_clip_r <= 1'b1;
            end else begin
              out_norm_r <= r_val[15:0];
              out_clip_r <= 1'b0;
            end
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/rms_normalizer_unit.sv */
// ============================================================================
// rms_normalizer_unit: two-pass RMS layer normalization
// Front end accepts and classifies items into a short queue; the back end
// accumulates squares, computes the inverse RMS and scales samples.
// ============================================================================
//
// Channel   Ports                                      Transfer
// --------  -----------------------------------------  ---------------------
// input     start, busy, in_kind, in_sample, in_gain,  start && !busy
//           in_end_of_pass
// result    out_valid, out_normalized, out_clipped     out_valid, one cycle
// config    cfg_we, cfg_wdata                          cfg_we
//
// An accumulate item is summed in the cycle it leaves the queue; a normalize
// item has its product formed in sg_r and is then rounded, clipped and
// registered onto the ports in ST_NM2. An item that closes a pass runs up to
// SUM_W divide steps, fifteen normalizing shifts and five Newton steps of
// three shift-and-add multiplies each; the back end takes no new item until
// it is done. Reset is synchronous and active low and clears the queue, the
// sums and the inverse RMS, and sets epsilon to 17. The receiver cannot stall;
// busy rises only while the two-entry queue is full.
// ============================================================================
module rms_normalizer_unit #(
  parameter int unsigned MAX_LENGTH = rmsn_pkg::MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_sample,
  input  logic [15:0] in_gain,
  input  logic        in_end_of_pass,
  output logic        out_valid,
  output logic [15:0] out_normalized,
  output logic        out_clipped,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // The count must hold MAX_LENGTH itself; each square is at most 2^30.
  localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned SUM_W = 30 + CNT_W;

  logic               q_valid;
  logic               q_pop;
  rmsn_pkg::item_t    q_head;
  rmsn_pkg::mul_req_t mreq;
  rmsn_pkg::mul_rsp_t mrsp;

  // Front end: classification and the queue that decouples the two sides.
  rmsn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_sample      (in_sample),
    .in_gain        (in_gain),
    .in_end_of_pass (in_end_of_pass),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  // Shared multiplier used by the Newton iteration.
  rmsn_seqmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // Back end: the sequencer that carries out each item.
  rmsn_back #(
    .MAX_LENGTH (MAX_LENGTH),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .mreq           (mreq),
    .mrsp           (mrsp),
    .out_valid      (out_valid),
    .out_normalized (out_normalized),
    .out_clipped    (out_clipped)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: regression bench for rms_normalizer_unit
// Streams accumulate and normalize items through the command port, predicts
// every normalized result in the bench and compares each strobed result with
// the oldest prediction, over several epsilon settings.
// ============================================================================
module tb;

  localparam int unsigned VEC_MAX = 4096;
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_NORM = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic [15:0] gain;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [15:0] normalized;
    logic        clipped;
  } norm_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = 1'b0;
  logic [15:0] in_sample = '0;
  logic [15:0] in_gain = '0;
  logic        in_end_of_pass = 1'b0;
  logic        out_valid;
  logic [15:0] out_normalized;
  logic        out_clipped;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        accepted = 1'b0;

  rms_normalizer_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_sample(in_sample), .in_gain(in_gain),
    .in_end_of_pass(in_end_of_pass), .out_valid(out_valid),
    .out_normalized(out_normalized), .out_clipped(out_clipped),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Bench copy of the block's state.
  logic [47:0] sq_sum;
  logic [12:0] elem_cnt;
  logic [31:0] inv_rms;
  logic [15:0] eps_reg;

  cmd_t      pending_cmds[$];
  norm_res_t expected_norms[$];
  int        mismatches = 0;

  // Fixed-point inverse square root; returns Q0.32.
  function automatic logic [31:0] isqrt_q20(logic [63:0] m);
    logic [63:0] f, z, p, t;
    logic [127:0] y;
    int k;
    k = 0;
    if (m == 0) return 32'hFFFF_FFFF;
    f = m;
    while (f < 64'h4000_0000) begin
      f = f << 2;
      k++;
    end
    z = (f < 64'h8000_0000) ? 64'd1805811301 : 64'd1276901417;
    for (int i = 0; i < 5; i++) begin
      p = ((z * z) >> 30) * f;
      t = (p > 64'hC000_0000_0000_0000) ? 64'd0 : 64'hC000_0000_0000_0000 - p;
      z = (z * (t >> 31)) >> 32;
      if (z > 64'h8000_0000) z = 64'h8000_0000;
    end
    y = ({64'd0, z} << k) >> 14;
    if (y > 128'hFFFF_FFFF) y = 128'hFFFF_FFFF;
    return y[31:0];
  endfunction

  // Advances the bench state by one accepted command.
  task automatic predict_norm(cmd_t c);
    logic signed [31:0] s, g, sg;
    logic [63:0] mag, r, mean;
    norm_res_t res;
    s = $signed(c.sample);
    g = $signed(c.gain);
    if (c.kind == KIND_ACC) begin
      if (elem_cnt < VEC_MAX) begin
        mag = (s < 0) ? 64'(-s) : 64'(s);
        sq_sum = 48'(sq_sum + mag * mag);
        elem_cnt = elem_cnt + 13'd1;
      end
      if (c.last) begin
        mean = (elem_cnt != 0) ? {16'd0, sq_sum} / {51'd0, elem_cnt} : 64'd0;
        inv_rms = isqrt_q20(mean + 64'(eps_reg));
        sq_sum = '0;
        elem_cnt = '0;
      end
    end else begin
      sg = s * g;
      mag = (sg < 0) ? 64'(-sg) : 64'(sg);
      r = (mag * 64'(inv_rms) + (64'd1 << 33)) >> 34;
      res.clipped = 1'b0;
      if (sg < 0) begin
        if (r > 64'd32768) begin
          r = 64'd32768;
          res.clipped = 1'b1;
        end
        res.normalized = 16'(17'h10000 - r[16:0]);
      end else begin
        if (r > 64'd32767) begin
          r = 64'd32767;
          res.clipped = 1'b1;
        end
        res.normalized = r[15:0];
      end
      expected_norms.push_back(res);
    end
  endtask

  // A transfer is recorded at the rising edge where it happens.
  always @(posedge clk) begin
    accepted <= rst_n && start && !busy;
  end

  // Driver: bursts of random length, random gaps, changes on the falling edge.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && accepted) begin
      predict_norm(pending_cmds.pop_front());
    end
    if (rst_n && (!start || accepted)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        start <= 1'b1;
        in_kind <= pending_cmds[0].kind;
        in_sample <= pending_cmds[0].sample;
        in_gain <= pending_cmds[0].gain;
        in_end_of_pass <= pending_cmds[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40, 0);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are taken at the rising edge.
  always @(posedge clk) begin
    norm_res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_norms.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_normalized);
      end else begin
        exp_r = expected_norms.pop_front();
        if (exp_r.normalized !== out_normalized || exp_r.clipped !== out_clipped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b, got %h/%b", exp_r.normalized,
                     exp_r.clipped, out_normalized, out_clipped);
        end
      end
    end
  end

  function automatic cmd_t mk(logic kind, logic [15:0] s, logic [15:0] g,
                              logic last);
    cmd_t c;
    c.kind = kind;
    c.sample = s;
    c.gain = g;
    c.last = last;
    return c;
  endfunction

  // Waits until every queued command has gone and every result has come;
  // the tail covers several passes still closing inside the block.
  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_norms.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_eps(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    eps_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queues a pass of random content, then as many normalize items of random samples.
  task automatic queue_vector(int len, int scale);
    logic [15:0] s;
    for (int i = 0; i < len; i++) begin
      s = (scale == 0) ? 16'($urandom) : 16'($signed($urandom_range(2 * scale, 0)) - scale);
      pending_cmds.push_back(mk(KIND_ACC, s, 16'($urandom), i == len - 1));
    end
    for (int i = 0; i < len; i++)
      pending_cmds.push_back(mk(KIND_NORM, 16'($urandom), 16'($urandom),
                                1'($urandom)));
  endtask

  initial begin
    int total;
    int len;
    sq_sum = '0;
    elem_cnt = '0;
    inv_rms = '0;
    eps_reg = 16'd17;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: normalize before any closed pass, extremes, a zero sample, a one-item pass.
    pending_cmds.push_back(mk(KIND_NORM, 16'h7FFF, 16'h7FFF, 1'b1));
    pending_cmds.push_back(mk(KIND_ACC, 16'h8000, 16'h1234, 1'b0));
    pending_cmds.push_back(mk(KIND_ACC, 16'h7FFF, 16'hFFFF, 1'b1));
    pending_cmds.push_back(mk(KIND_NORM, 16'h8000, 16'h8000, 1'b0));
    pending_cmds.push_back(mk(KIND_NORM, 16'h7FFF, 16'h8000, 1'b0));
    pending_cmds.push_back(mk(KIND_NORM, 16'h0000, 16'h7FFF, 1'b0));
    pending_cmds.push_back(mk(KIND_NORM, 16'hFFFF, 16'h0001, 1'b0));
    pending_cmds.push_back(mk(KIND_ACC, 16'h0001, 16'h0000, 1'b1));
    pending_cmds.push_back(mk(KIND_NORM, 16'h7FFF, 16'h7FFF, 1'b0));
    pending_cmds.push_back(mk(KIND_NORM, 16'h8000, 16'h7FFF, 1'b0));
    drain();

    // Epsilon zero with an all-zero vector saturates the inverse RMS.
    write_eps(16'd0);
    pending_cmds.push_back(mk(KIND_ACC, 16'h0000, 16'h0000, 1'b0));
    pending_cmds.push_back(mk(KIND_ACC, 16'h0000, 16'h0000, 1'b1));
    pending_cmds.push_back(mk(KIND_NORM, 16'h0001, 16'h0001, 1'b0));
    pending_cmds.push_back(mk(KIND_NORM, 16'hFFFF, 16'h0001, 1'b0));
    pending_cmds.push_back(mk(KIND_NORM, 16'h0000, 16'h4000, 1'b0));
    drain();

    // Random phases across several epsilon settings.
    total = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_eps(16'd17);
        1: write_eps(16'($urandom));
        2: write_eps(16'd0);
        default: write_eps(16'hFFFF);
      endcase
      while (total < 380 * (ph + 1)) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
        if ($urandom_range(9, 0) == 0) begin
          pending_cmds.push_back(mk(1'($urandom), 16'($urandom), 16'($urandom),
                                    1'($urandom)));
          total++;
        end else begin
          queue_vector(len, ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(4096, 1));
          total += 2 * len;
        end
      end
      drain();
    end

    if (mismatches == 0 && expected_norms.size() == 0)
      $display("rms_normalizer_unit regression: pass");
    else
      $display("rms_normalizer_unit regression: fail");
    $finish;
  end

  initial begin
    #100ms;
    $display("rms_normalizer_unit regression: fail");
    $finish;
  end
endmodule

/* files.f */
hdl/rmsn_pkg.sv
hdl/rmsn_front.sv
hdl/rmsn_seqmul.sv
hdl/rmsn_back.sv
hdl/rms_normalizer_unit.sv
test/tb.sv
